// ----- rtl/core/window_overlap_add_core_macros.svh -----
`ifndef WINDOW_OVERLAP_ADD_CORE_MACROS_SVH
`define WINDOW_OVERLAP_ADD_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WOA_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WOA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/woa_pkg.sv -----
`default_nettype none

package woa_pkg;

  localparam int DEF_MAX_WINDOW = 32;
  localparam int GRAD_W         = 24;
  localparam int ACC_W          = 29;
  localparam int CFG_W          = 6;
  localparam int CFG_IDX_W      = 1;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 32;
  localparam int LEN_CLAMP_W    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_STEP    = 1'b1;

  localparam logic [CFG_W-1:0] RST_WINDOW_SIZE = 6'd4;
  localparam logic [CFG_W-1:0] RST_HOP_STEP    = 6'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_EMIT_RD,
    ST_EMIT
  } woa_state_t;

  typedef struct packed {
    logic rd_en;
    logic acc_wr;
    logic inval;
    logic clr_all;
  } woa_mem_ctl_t;

  // Zero acts as one, anything above the buffer depth acts as the depth.
  function automatic logic [LEN_CLAMP_W-1:0] clamp_len(
    input logic [CFG_W-1:0]       v,
    input logic [LEN_CLAMP_W-1:0] maxw
  );
    if (v == '0) return LEN_CLAMP_W'(1);
    if ({1'b0, v} > maxw) return maxw;
    return {1'b0, v};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/woa_buf.sv -----
`default_nettype none

module woa_buf #(
  parameter int MAX_WINDOW = woa_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire woa_pkg::woa_mem_ctl_t             ctl,
  input  wire logic [$clog2(MAX_WINDOW)-1:0]     rd_addr,
  input  wire logic [$clog2(MAX_WINDOW)-1:0]     wr_addr,
  input  wire logic signed [woa_pkg::ACC_W-1:0]  wr_data,
  output logic signed [woa_pkg::ACC_W-1:0]       rd_data,
  output logic                                   rd_ok
);
  import woa_pkg::*;

  logic signed [ACC_W-1:0] mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]   vld;

  always_ff @(posedge clk) begin
    if (ctl.acc_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // An entry without its valid bit reads as zero.
  always_ff @(posedge clk) begin
    if (rst || ctl.clr_all) begin
      vld <= '0;
    end else if (ctl.acc_wr) begin
      vld[wr_addr] <= 1'b1;
    end else if (ctl.inval) begin
      vld[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (ctl.rd_en) begin
      rd_ok <= vld[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/woa_seq.sv -----
`default_nettype none
`include "window_overlap_add_core_macros.svh"

module woa_seq #(
  parameter int MAX_WINDOW = woa_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_clear,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]      win_len,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]      hop_len,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic signed [woa_pkg::GRAD_W-1:0]    grad_value,
  input  wire logic                                 final_window,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic signed [woa_pkg::ACC_W-1:0]          sample_value,
  output logic                                      run_last,
  output logic                                      signal_end,
  output woa_pkg::woa_mem_ctl_t                     mem_ctl,
  output logic [$clog2(MAX_WINDOW)-1:0]             rd_addr,
  output logic [$clog2(MAX_WINDOW)-1:0]             wr_addr,
  output logic signed [woa_pkg::ACC_W-1:0]          wr_data,
  input  wire logic signed [woa_pkg::ACC_W-1:0]     rd_data,
  input  wire logic                                 rd_ok
);
  import woa_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int SW = AW + 1;
  localparam logic [SW-1:0] DEPTH = SW'(MAX_WINDOW);

  woa_state_t state, state_next;

  logic [AW-1:0]           col;
  logic [AW-1:0]           base;
  logic [AW-1:0]           k;
  logic [LW-1:0]           n_len;
  logic                    fin_r;
  logic [AW-1:0]           slot_r;
  logic signed [GRAD_W-1:0] g_r;

  logic [SW-1:0] addend, sum_addr;
  logic [AW-1:0] slot_addr;
  logic [SW-1:0] col_inc, k_inc;
  logic          col_end, k_last, in_win;
  logic          s_fire, m_fire;

  // One circular address adder, its offset picked by state.
  always_comb begin
    addend = {1'b0, col};
    unique case (state)
      ST_IDLE:    addend = {1'b0, col};
      ST_ACC:     addend = {1'b0, col};
      ST_EMIT_RD: addend = {1'b0, k};
      ST_EMIT:    addend = SW'(hop_len);
      default:    addend = {1'b0, col};
    endcase
  end

  assign sum_addr  = {1'b0, base} + addend;
  assign slot_addr = AW'((sum_addr >= DEPTH) ? (sum_addr - DEPTH) : sum_addr);

  assign col_inc = {1'b0, col} + SW'(1);
  assign k_inc   = {1'b0, k} + SW'(1);
  assign col_end = (col_inc >= SW'(win_len));
  assign k_last  = (k_inc == SW'(n_len));
  assign in_win  = ({1'b0, k} < SW'(win_len));

  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;

  assign wr_addr = slot_r;
  assign wr_data = (rd_ok ? rd_data : '0) + {{(ACC_W - GRAD_W){g_r[GRAD_W-1]}}, g_r};

  assign sample_value = (in_win && rd_ok) ? rd_data : '0;
  assign run_last     = k_last;
  assign signal_end   = k_last && fin_r;

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_ctl    = '0;
    rd_addr    = slot_addr;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready      = !rst;
        mem_ctl.rd_en = s_tvalid && !rst;
        if (s_tvalid) state_next = ST_ACC;
      end
      ST_ACC: begin
        mem_ctl.acc_wr = 1'b1;
        state_next     = col_end ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        mem_ctl.rd_en = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        m_tvalid        = 1'b1;
        mem_ctl.inval   = m_tready && in_win;
        mem_ctl.clr_all = m_tready && k_last && fin_r;
        if (m_tready) state_next = k_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
    if (cfg_clear) mem_ctl.clr_all = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      col   <= '0;
      base  <= '0;
      k     <= '0;
      n_len <= LW'(1);
      fin_r <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) fin_r <= final_window;
        end
        ST_ACC: begin
          if (col_end) begin
            col   <= '0;
            k     <= '0;
            n_len <= fin_r ? win_len : hop_len;
          end else begin
            col <= AW'(col_inc);
          end
        end
        ST_EMIT: begin
          if (m_fire) begin
            if (k_last) begin
              k    <= '0;
              base <= fin_r ? '0 : slot_addr;
            end else begin
              k <= AW'(k_inc);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      g_r    <= grad_value;
      slot_r <= slot_addr;
    end else if (state == ST_EMIT_RD) begin
      slot_r <= slot_addr;
    end
  end

  `WOA_ASSERT_NOW(a_one_side, clk, rst, s_tready, !m_tvalid, "input and output open together")
  `WOA_ASSERT_NOW(a_col_range, clk, rst, 1'b1, {1'b0, col} < SW'(win_len), "column out of window")
  `WOA_ASSERT_NOW(a_base_range, clk, rst, 1'b1, {1'b0, base} < DEPTH, "base out of buffer")
  `WOA_ASSERT_NEXT(a_last_idle, clk, rst, m_fire && run_last && !cfg_clear, s_tready, "no return to idle")

endmodule

`default_nettype wire

// ----- rtl/core/window_overlap_add_core.sv -----
// Each input transaction is a buffer read, then add and write back.
// A transaction that completes a window is then followed by n output transactions,
// n = hop_step (or window_size on the final window), each a buffer read, then held until m_tready.
// Throughput is set by the sequencer and its shared address adder; the buffer has separate read and write ports.
// rst is synchronous: window_size = 4, hop_step = 1, all buffer entries read as zero.
// A register write also restarts the stream; there is no clearing pass.
`default_nettype none

module window_overlap_add_core #(
  parameter int MAX_WINDOW = woa_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [woa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [woa_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [woa_pkg::IN_TDATA_W-1:0]      s_tdata,  // [23:0] grad_value
  input  wire logic                                s_tuser,  // [0] final_window
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [woa_pkg::OUT_TDATA_W-1:0]          m_tdata,  // [28:0] sample_value
  output logic                                     m_tlast,  // run_last
  output logic                                     m_tuser   // [0] signal_end
);
  import woa_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam logic [LEN_CLAMP_W-1:0] MAXL = LEN_CLAMP_W'(MAX_WINDOW);

  logic [LW-1:0]            win_len, hop_len;
  woa_mem_ctl_t             mem_ctl;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic signed [ACC_W-1:0]  wr_data, rd_data, sample_value;
  logic                     rd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= LW'(clamp_len(RST_WINDOW_SIZE, MAXL));
      hop_len <= LW'(clamp_len(RST_HOP_STEP, MAXL));
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE: win_len <= LW'(clamp_len(cfg_data, MAXL));
        REG_HOP_STEP:    hop_len <= LW'(clamp_len(cfg_data, MAXL));
        default: ;
      endcase
    end
  end

  woa_seq #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_clear    (cfg_we),
    .win_len      (win_len),
    .hop_len      (hop_len),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .grad_value   (s_tdata[GRAD_W-1:0]),
    .final_window (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .sample_value (sample_value),
    .run_last     (m_tlast),
    .signal_end   (m_tuser),
    .mem_ctl      (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_data      (rd_data),
    .rd_ok        (rd_ok)
  );

  woa_buf #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_buf (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .rd_ok   (rd_ok)
  );

  assign m_tdata = {{(OUT_TDATA_W - ACC_W){1'b0}}, sample_value};

endmodule

`default_nettype wire
